### sv/assert_macros.svh
// assertion helpers used by the checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define AST_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while in reset
`define AST_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### sv/bko_pkg.sv
package bko_pkg;

    localparam int ENTRIES_DEFAULT   = 16;
    localparam int TIME_BITS_DEFAULT = 48;

    localparam int IDX_BITS     = 4;
    localparam int CNT_BITS     = 8;
    localparam int SEC_BITS     = 16;
    localparam int CFG_IDX_BITS = 1;
    localparam int CFG_BITS     = 16;

    localparam logic [SEC_BITS-1:0] DECAY_WINDOW_RESET   = 16'd300;
    localparam logic [SEC_BITS-1:0] PROBE_INTERVAL_RESET = 16'd30;
    localparam logic [31:0]         BACKOFF_CAP          = 32'd300;
    localparam int                  MAX_EXP              = 9;

    typedef enum logic [2:0] {
        REQ_QUERY   = 3'd0,
        REQ_FAILURE = 3'd1,
        REQ_SUCCESS = 3'd2,
        REQ_PROBE   = 3'd3,
        REQ_CLEAR   = 3'd4
    } req_code_t;

    typedef enum logic [2:0] {
        KIND_RATE_LIMIT = 3'd0,
        KIND_TRANSIENT  = 3'd1,
        KIND_TIMEOUT    = 3'd2,
        KIND_AUTH       = 3'd3,
        KIND_BILLING    = 3'd4,
        KIND_OTHER      = 3'd5
    } err_kind_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_DECAY_WINDOW   = 1'b0,
        REG_PROBE_INTERVAL = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_UPDATE,
        ST_REPORT
    } state_t;

    typedef struct packed {
        logic [2:0]          req_type;
        logic [IDX_BITS-1:0] entry_index;
        logic [2:0]          error_kind;
        logic [SEC_BITS-1:0] hint_secs;
        logic [47:0]         time_now;
    } req_item_t;

    typedef struct packed {
        logic                entry_present;
        logic                in_cooldown;
        logic [SEC_BITS-1:0] remaining_seconds;
        logic [CNT_BITS-1:0] failures_so_far;
        logic                probe_granted;
    } rsp_item_t;

    function automatic logic [31:0] kind_base(input logic [2:0] kind);
        logic [31:0] b;
        case (kind)
            KIND_RATE_LIMIT: b = 32'd10;
            KIND_TRANSIENT:  b = 32'd5;
            KIND_TIMEOUT:    b = 32'd3;
            KIND_AUTH:       b = 32'd60;
            KIND_BILLING:    b = 32'd300;
            KIND_OTHER:      b = 32'd30;
            default:         b = 32'd30;
        endcase
        return b;
    endfunction

    // base * 2^(count-1), capped
    function automatic logic [SEC_BITS-1:0] backoff_secs(input logic [2:0] kind,
                                                         input logic [CNT_BITS-1:0] count);
        logic [CNT_BITS-1:0] e;
        logic [31:0]         v;
        e = (count != '0) ? count - CNT_BITS'(1) : '0;
        if (e > CNT_BITS'(MAX_EXP))
            e = CNT_BITS'(MAX_EXP);
        v = kind_base(kind) << e;
        return (v > BACKOFF_CAP) ? BACKOFF_CAP[SEC_BITS-1:0] : v[SEC_BITS-1:0];
    endfunction

endpackage

### sv/bko_ram.sv
module bko_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 wen,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/per_channel_backoff_tracker_core.sv
// channel  direction  handshake             payload
// req      in         req_valid, req_stall  bko_pkg::req_item_t
// rsp      out        rsp_valid, rsp_stall  bko_pkg::rsp_item_t
// cfg      in         cfg_wen               cfg_index, cfg_wdata
//
// an item passes from accept to the next accept through record read, evaluate,
// write back and report, in the one read-modify-write pass over the record memory
// req_stall is high from accept until the result is loaded into the rsp register
// the rsp register holds under rsp_stall while the next item is accepted and worked
// reset clears the valid bits and the rsp valid flag and sets the config registers
// to defaults; the record memory needs no clearing, an invalid record is never used
module per_channel_backoff_tracker_core #(
    parameter int ENTRIES   = bko_pkg::ENTRIES_DEFAULT,
    parameter int TIME_BITS = bko_pkg::TIME_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  bko_pkg::req_item_t                  req_item,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output bko_pkg::rsp_item_t                  rsp_item,
    input  logic                                cfg_wen,
    input  logic [bko_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [bko_pkg::CFG_BITS-1:0]        cfg_wdata
);

    // only channels the index field can reach need storage
    localparam int DEPTH    = (ENTRIES < (1 << bko_pkg::IDX_BITS)) ? ENTRIES
                                                                   : (1 << bko_pkg::IDX_BITS);
    localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int T        = TIME_BITS;
    localparam int CB       = bko_pkg::CNT_BITS;
    localparam int REC_BITS = CB + 3 * T;

    bko_pkg::state_t    state_reg, state_next;
    bko_pkg::req_item_t req_reg;
    logic [AW-1:0]      addr_reg;
    logic               hit_reg;

    logic [DEPTH-1:0]   valid_bits_reg;
    logic [15:0]        decay_window_reg;
    logic [15:0]        probe_interval_reg;

    logic               rec_vld_reg;
    logic [CB-1:0]      rec_cnt_reg;
    logic [T-1:0]       rec_dl_reg;
    logic [T-1:0]       rec_lfail_reg;
    logic [T-1:0]       rec_lprobe_reg;
    logic               decay_hit_reg;
    logic               probe_free_reg;
    logic               probe_due_reg;
    logic               grant_reg;
    logic               wr_reg;
    logic [15:0]        cooldown_reg;

    logic               rsp_valid_reg;
    bko_pkg::rsp_item_t rsp_item_reg;

    logic               accept;
    logic               ram_wen;
    logic               load_rsp;
    logic [REC_BITS-1:0] ram_rdata;
    logic [REC_BITS-1:0] ram_wdata;

    logic [T-1:0]       now;
    logic               is_fail;
    logic               is_succ;
    logic               is_probe;
    logic               is_clear;

    logic               rd_vld;
    logic [CB-1:0]      m_cnt;
    logic [T-1:0]       m_dl;
    logic [T-1:0]       m_lfail;
    logic [T-1:0]       m_lprobe;
    logic [T-1:0]       el_fail;
    logic [T-1:0]       el_probe;

    logic [CB-1:0]      cnt_base;
    logic [CB-1:0]      cnt_new;
    logic [15:0]        cooldown;

    logic [T:0]         dl_sum;
    logic [T-1:0]       dl_new;
    logic [T-1:0]       dl_wr;

    logic [T-1:0]       rem_diff;
    bko_pkg::rsp_item_t rsp_next;

    assign accept = req_valid && !req_stall;
    assign now    = T'(req_reg.time_now);

    assign is_fail  = hit_reg && (req_reg.req_type == bko_pkg::REQ_FAILURE);
    assign is_succ  = hit_reg && (req_reg.req_type == bko_pkg::REQ_SUCCESS);
    assign is_probe = (req_reg.req_type == bko_pkg::REQ_PROBE);
    assign is_clear = (req_reg.req_type == bko_pkg::REQ_CLEAR);

    bko_ram #(
        .WIDTH (REC_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .wen   (ram_wen),
        .waddr (addr_reg),
        .wdata (ram_wdata),
        .raddr (req_item.entry_index[AW-1:0]),
        .rdata (ram_rdata)
    );

    // ---------------- state machine ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bko_pkg::ST_IDLE:
            begin
                if (req_valid)
                    state_next = bko_pkg::ST_READ;
            end
            bko_pkg::ST_READ:   state_next = bko_pkg::ST_EVAL;
            bko_pkg::ST_EVAL:   state_next = bko_pkg::ST_UPDATE;
            bko_pkg::ST_UPDATE: state_next = bko_pkg::ST_REPORT;
            bko_pkg::ST_REPORT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                    state_next = bko_pkg::ST_IDLE;
            end
            default:            state_next = bko_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        req_stall = 1'b1;
        ram_wen   = 1'b0;
        load_rsp  = 1'b0;
        case (state_reg)
            bko_pkg::ST_IDLE:   req_stall = 1'b0;
            bko_pkg::ST_UPDATE: ram_wen   = wr_reg;
            bko_pkg::ST_REPORT: load_rsp  = !rsp_valid_reg || !rsp_stall;
            default:            req_stall = 1'b1;
        endcase
    end

    // ---------------- record read ----------------
    always_comb
    begin
        rd_vld   = hit_reg && valid_bits_reg[addr_reg];
        m_cnt    = rd_vld ? ram_rdata[REC_BITS-1 -: CB] : '0;
        m_dl     = rd_vld ? ram_rdata[3*T-1 -: T]       : '0;
        m_lfail  = rd_vld ? ram_rdata[2*T-1 -: T]       : '0;
        m_lprobe = rd_vld ? ram_rdata[T-1:0]            : '0;
        el_fail  = (now >= m_lfail)  ? now - m_lfail  : '0;
        el_probe = (now >= m_lprobe) ? now - m_lprobe : '0;
    end

    // ---------------- evaluate ----------------
    always_comb
    begin
        cnt_base = decay_hit_reg ? '0 : rec_cnt_reg;
        cnt_new  = (cnt_base == '1) ? cnt_base : cnt_base + CB'(1);
        cooldown = (req_reg.hint_secs != '0) ? req_reg.hint_secs
                                             : bko_pkg::backoff_secs(req_reg.error_kind,
                                                                     cnt_new);
    end

    // ---------------- write back ----------------
    always_comb
    begin
        dl_sum    = {1'b0, now} + (T+1)'(cooldown_reg);
        dl_new    = dl_sum[T] ? '1 : dl_sum[T-1:0];
        dl_wr     = is_fail ? dl_new : rec_dl_reg;
        ram_wdata = {rec_cnt_reg, dl_wr, rec_lfail_reg, rec_lprobe_reg};
    end

    // ---------------- report ----------------
    always_comb
    begin
        rem_diff = (rec_dl_reg > now) ? rec_dl_reg - now : '0;
        rsp_next = '0;
        if (rec_vld_reg)
        begin
            rsp_next.entry_present     = 1'b1;
            rsp_next.in_cooldown       = now < rec_dl_reg;
            rsp_next.remaining_seconds = (rem_diff > T'(16'hFFFF)) ? 16'hFFFF
                                                                   : rem_diff[15:0];
            rsp_next.failures_so_far   = rec_cnt_reg;
        end
        rsp_next.probe_granted = grant_reg;
    end

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= bko_pkg::ST_IDLE;
            valid_bits_reg     <= '0;
            decay_window_reg   <= bko_pkg::DECAY_WINDOW_RESET;
            probe_interval_reg <= bko_pkg::PROBE_INTERVAL_RESET;
            rsp_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wen)
            begin
                case (cfg_index)
                    bko_pkg::REG_DECAY_WINDOW:   decay_window_reg   <= cfg_wdata;
                    bko_pkg::REG_PROBE_INTERVAL: probe_interval_reg <= cfg_wdata;
                    default:                     decay_window_reg   <= decay_window_reg;
                endcase
            end
            if (state_reg == bko_pkg::ST_UPDATE)
            begin
                if (is_clear)
                    valid_bits_reg <= '0;
                else if (is_fail)
                    valid_bits_reg[addr_reg] <= 1'b1;
                else if (is_succ)
                    valid_bits_reg[addr_reg] <= 1'b0;
            end
            if (load_rsp)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg  <= req_item;
            addr_reg <= req_item.entry_index[AW-1:0];
            hit_reg  <= int'(req_item.entry_index) < ENTRIES;
        end
        case (state_reg)
            bko_pkg::ST_READ:
            begin
                rec_vld_reg    <= rd_vld;
                rec_cnt_reg    <= m_cnt;
                rec_dl_reg     <= m_dl;
                rec_lfail_reg  <= m_lfail;
                rec_lprobe_reg <= m_lprobe;
                decay_hit_reg  <= (m_cnt != '0) && (el_fail > T'(decay_window_reg));
                probe_free_reg <= !rd_vld || (now >= m_dl);
                probe_due_reg  <= el_probe >= T'(probe_interval_reg);
            end
            bko_pkg::ST_EVAL:
            begin
                grant_reg <= is_probe && (probe_free_reg || probe_due_reg);
                wr_reg    <= is_fail || (is_probe && !probe_free_reg && probe_due_reg);
                cooldown_reg <= cooldown;
                if (is_fail)
                begin
                    rec_vld_reg   <= 1'b1;
                    rec_cnt_reg   <= cnt_new;
                    rec_lfail_reg <= now;
                end
                else if (is_succ || is_clear)
                begin
                    rec_vld_reg <= 1'b0;
                end
                else if (is_probe && !probe_free_reg && probe_due_reg)
                begin
                    // granted by the interval rule only
                    rec_lprobe_reg <= now;
                end
            end
            bko_pkg::ST_UPDATE:
            begin
                rec_dl_reg <= dl_wr;
            end
            default:
            begin
                rec_dl_reg <= rec_dl_reg;
            end
        endcase
        if (load_rsp)
            rsp_item_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

endmodule

### sv/bko_checker.sv
`include "assert_macros.svh"

module bko_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             req_valid,
    input logic                             req_stall,
    input logic                             rsp_valid,
    input logic                             rsp_stall,
    input bko_pkg::rsp_item_t               rsp_item
);

    // a held result stays put
    `AST_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_item))

    // one item at a time: busy right after an accept
    `AST_NEXT(a_busy_after_accept, clk, rst_n, req_valid && !req_stall, req_stall)

    // cooldown flag and remaining time agree
    `AST_IMPLY(a_cooldown_rem, clk, rst_n, rsp_valid,
               rsp_item.in_cooldown == (rsp_item.remaining_seconds != 16'd0))

    // a live record has counted at least one failure, an absent one reports nothing
    `AST_IMPLY(a_present_count, clk, rst_n, rsp_valid,
               rsp_item.entry_present == (rsp_item.failures_so_far != 8'd0))

endmodule

bind per_channel_backoff_tracker_core bko_checker u_bko_checker (.*);
